// ===== hdl/amc_pkg.sv =====
package amc_pkg;

	localparam int WordW = 18;
	localparam int AddrW = 13;

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_EXEC    = 2'd2;
	localparam logic [1:0] OP_RESTART = 2'd3;

	localparam logic CFG_SWITCHES = 1'b0;
	localparam logic CFG_START    = 1'b1;

	localparam logic [17:0] W_KRB = 18'o700312;
	localparam logic [17:0] W_TLS = 18'o700406;

	localparam logic [17:0] W_NOP = 18'o740000;
	localparam logic [17:0] W_CMA = 18'o740001;
	localparam logic [17:0] W_CML = 18'o740002;
	localparam logic [17:0] W_OAS = 18'o740004;
	localparam logic [17:0] W_LAS = 18'o750004;
	localparam logic [17:0] W_RAL = 18'o740010;
	localparam logic [17:0] W_RCL = 18'o744010;
	localparam logic [17:0] W_RTL = 18'o742010;
	localparam logic [17:0] W_RAR = 18'o740020;
	localparam logic [17:0] W_RCR = 18'o744020;
	localparam logic [17:0] W_RTR = 18'o742020;
	localparam logic [17:0] W_HLT = 18'o740040;
	localparam logic [17:0] W_SZA = 18'o740200;
	localparam logic [17:0] W_SNA = 18'o741200;
	localparam logic [17:0] W_SPA = 18'o741100;
	localparam logic [17:0] W_SMA = 18'o740100;
	localparam logic [17:0] W_SZL = 18'o741400;
	localparam logic [17:0] W_SNL = 18'o740400;
	localparam logic [17:0] W_SKP = 18'o741000;
	localparam logic [17:0] W_CLL = 18'o744000;
	localparam logic [17:0] W_STL = 18'o744002;
	localparam logic [17:0] W_CLA = 18'o750000;
	localparam logic [17:0] W_CLC = 18'o750001;
	localparam logic [17:0] W_GLK = 18'o750020;

	localparam logic [3:0] OC_CAL = 4'd0;
	localparam logic [3:0] OC_DAC = 4'd1;
	localparam logic [3:0] OC_JMS = 4'd2;
	localparam logic [3:0] OC_DZM = 4'd3;
	localparam logic [3:0] OC_LAC = 4'd4;
	localparam logic [3:0] OC_XOR = 4'd5;
	localparam logic [3:0] OC_ADD = 4'd6;
	localparam logic [3:0] OC_TAD = 4'd7;
	localparam logic [3:0] OC_XCT = 4'd8;
	localparam logic [3:0] OC_ISZ = 4'd9;
	localparam logic [3:0] OC_AND = 4'd10;
	localparam logic [3:0] OC_SAD = 4'd11;
	localparam logic [3:0] OC_JMP = 4'd12;
	localparam logic [3:0] OC_EAE = 4'd13;
	localparam logic [3:0] OC_IOT = 4'd14;
	localparam logic [3:0] OC_OPR = 4'd15;

	typedef struct packed {
		logic [1:0]  op;
		logic [12:0] address;
		logic [17:0] data;
		logic [7:0]  key_char;
	} amc_in_t;

	typedef struct packed {
		logic [12:0] pc_out;
		logic [17:0] acc_out;
		logic        link_out;
		logic        halted;
		logic        bad_instruction;
		logic        tty_valid;
		logic [7:0]  tty_char;
		logic [17:0] read_data;
		logic [3:0]  step_cycles;
	} amc_out_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDWAIT,
		ST_FETCH,
		ST_DECODE,
		ST_INDWAIT,
		ST_OPWAIT,
		ST_EXEC,
		ST_ISZWR,
		ST_DONE
	} amc_state_t;

endpackage

// ===== hdl/accumulator_minicomputer_core.sv =====
// Accumulator minicomputer core with MEM_WORDS words of internal memory.
// The input channel (in_valid, in_stall, in_data) carries one command per
// transfer: write a memory word, read a memory word, execute one instruction
// at the program counter, or restart at the start address. Each accepted
// command gives exactly one transfer on the output channel (out_valid,
// out_stall, out_data) with the machine state after the command.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must write it only while idle, as the block itself leaves this unenforced.
// A write, a restart or an execute while halted goes straight to the done
// state; a read passes the read-wait state first. An execute passes fetch,
// decode and execute; an operand read, an indirect read and the ISZ write-back
// each add a state, and each chained XCT level passes decode, operand read and
// execute again, plus the indirect read when that level is indirect. Every
// step (fetch, indirect read, operand read, write-back) uses the one memory.
// One command is in flight at a time. After reset the memory is swept to
// zero, one word per cycle, with in_stall high during the sweep. The result
// register holds its transfer while out_stall is high; a new command is taken
// meanwhile into the work sequence, which waits before it presents its result.
module accumulator_minicomputer_core
	import amc_pkg::*;
#(
	parameter int MEM_WORDS     = 8192,
	parameter int MAX_XCT_CHAIN = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  amc_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output amc_out_t    out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [17:0] cfg_wdata
);
	localparam int MA = $clog2(MEM_WORDS);
	localparam int XW = $clog2(MAX_XCT_CHAIN + 1);

	amc_state_t state_q, state_d;
	logic [17:0] sw_q;
	logic [12:0] start_q;
	logic [12:0] pc_q;
	logic [17:0] ac_q;
	logic        link_q, halt_q, err_q;
	logic [MA:0] clr_q;
	logic [7:0]  key_q;
	logic [17:0] w_q;
	logic [12:0] ea_q;
	logic [XW-1:0] depth_q;
	logic [4:0]  cyc_q;
	logic        tv_q;
	logic [7:0]  tc_q;
	logic [17:0] rd_q;

	logic          we;
	logic [MA-1:0] waddr, raddr;
	logic [17:0]   wdata, rdata;

	amc_ram #(.Width(18), .Depth(MEM_WORDS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [3:0] code;
	assign code = w_q[17:14];
	logic       accept;
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;

	logic [18:0] sum;
	logic [17:0] inc;
	assign sum = {1'b0, ac_q} + {1'b0, rdata};
	assign inc = rdata + 18'd1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (clr_q == (MA + 1)'(MEM_WORDS - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					unique case (in_data.op)
						OP_READ: state_d = ST_RDWAIT;
						OP_EXEC: state_d = halt_q ? ST_DONE : ST_FETCH;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_RDWAIT:  state_d = ST_DONE;
			ST_FETCH:   state_d = ST_DECODE;
			ST_DECODE: begin
				if (w_q[13] && code != OC_IOT && code != OC_OPR) state_d = ST_INDWAIT;
				else if (code == OC_IOT || code == OC_OPR || code == OC_JMP ||
					code == OC_DAC || code == OC_DZM || code == OC_JMS ||
					code == OC_CAL || code == OC_EAE) state_d = ST_EXEC;
				else state_d = ST_OPWAIT;
			end
			ST_INDWAIT: state_d = ST_OPWAIT;
			ST_OPWAIT:  state_d = ST_EXEC;
			ST_EXEC: begin
				if (code == OC_XCT && depth_q < XW'(MAX_XCT_CHAIN)) state_d = ST_DECODE;
				else if (code == OC_ISZ) state_d = ST_ISZWR;
				else state_d = ST_DONE;
			end
			ST_ISZWR:   state_d = ST_DONE;
			ST_DONE:    if (!out_valid || !out_stall) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = ea_q[MA-1:0];
		wdata = 18'd0;
		raddr = ea_q[MA-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q[MA-1:0];
			end
			ST_IDLE: begin
				raddr = accept && in_data.op == OP_READ ? in_data.address[MA-1:0]
					: pc_q[MA-1:0];
				if (accept && in_data.op == OP_WRITE) begin
					we = 1'b1;
					waddr = in_data.address[MA-1:0];
					wdata = in_data.data;
				end
			end
			ST_DECODE: raddr = w_q[MA-1:0];
			ST_INDWAIT: raddr = rdata[MA-1:0];
			ST_EXEC: begin
				unique case (code)
					OC_CAL, OC_JMS: begin we = 1'b1; wdata = {5'd0, pc_q}; end
					OC_DAC: begin we = 1'b1; wdata = ac_q; end
					OC_DZM: we = 1'b1;
					default: ;
				endcase
			end
			ST_ISZWR: begin we = 1'b1; wdata = w_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			sw_q <= '0;
			start_q <= 13'o2000;
			pc_q <= 13'o2000;
			ac_q <= '0;
			link_q <= 1'b0;
			halt_q <= 1'b0;
			err_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_we) begin
				if (cfg_index == CFG_SWITCHES) sw_q <= cfg_wdata;
				else start_q <= cfg_wdata[12:0];
			end
			if (accept && in_data.op == OP_RESTART) begin
				pc_q <= start_q;
				halt_q <= 1'b0;
				err_q <= 1'b0;
			end
			if (state_q == ST_FETCH) pc_q <= pc_q + 13'd1;
			if (state_q == ST_EXEC) begin
				unique case (code)
					OC_CAL: begin ac_q <= {5'd0, pc_q}; pc_q <= ea_q + 13'd1; end
					OC_JMS: pc_q <= ea_q + 13'd1;
					OC_LAC: ac_q <= rdata;
					OC_XOR: ac_q <= ac_q ^ rdata;
					OC_AND: ac_q <= ac_q & rdata;
					OC_ADD: begin
						ac_q <= sum[17:0] + {17'd0, sum[18]};
						link_q <= link_q ^ sum[18];
					end
					OC_TAD: begin ac_q <= sum[17:0]; link_q <= link_q ^ sum[18]; end
					OC_SAD: if (ac_q != rdata) pc_q <= pc_q + 13'd1;
					OC_ISZ: if (inc == 18'd0) pc_q <= pc_q + 13'd1;
					OC_JMP: pc_q <= ea_q;
					OC_XCT: if (depth_q >= XW'(MAX_XCT_CHAIN)) begin
						halt_q <= 1'b1; err_q <= 1'b1;
					end
					OC_IOT: begin
						if (w_q == W_KRB) ac_q <= {10'd0, key_q};
						else if (w_q != W_TLS) begin halt_q <= 1'b1; err_q <= 1'b1; end
					end
					OC_OPR: begin
						case (w_q)
							W_NOP: ;
							W_CMA: ac_q <= ~ac_q;
							W_CML: link_q <= ~link_q;
							W_OAS: ac_q <= ac_q | sw_q;
							W_LAS: ac_q <= sw_q;
							W_RAL: begin ac_q <= {ac_q[16:0], link_q}; link_q <= ac_q[17]; end
							W_RCL: begin ac_q <= {ac_q[16:0], 1'b0}; link_q <= ac_q[17]; end
							W_RTL: begin ac_q <= {ac_q[15:0], link_q, ac_q[17]};
								link_q <= ac_q[16]; end
							W_RAR: begin ac_q <= {link_q, ac_q[17:1]}; link_q <= ac_q[0]; end
							W_RCR: begin ac_q <= {1'b0, ac_q[17:1]}; link_q <= ac_q[0]; end
							W_RTR: begin ac_q <= {ac_q[0], link_q, ac_q[17:2]};
								link_q <= ac_q[1]; end
							W_HLT: halt_q <= 1'b1;
							W_SZA: if (ac_q == 18'd0) pc_q <= pc_q + 13'd1;
							W_SNA: if (ac_q != 18'd0) pc_q <= pc_q + 13'd1;
							W_SPA: if (!ac_q[17]) pc_q <= pc_q + 13'd1;
							W_SMA: if (ac_q[17]) pc_q <= pc_q + 13'd1;
							W_SZL: if (!link_q) pc_q <= pc_q + 13'd1;
							W_SNL: if (link_q) pc_q <= pc_q + 13'd1;
							W_SKP: pc_q <= pc_q + 13'd1;
							W_CLL: link_q <= 1'b0;
							W_STL: link_q <= 1'b1;
							W_CLA: ac_q <= '0;
							W_CLC: ac_q <= '1;
							W_GLK: ac_q <= {link_q, ac_q[16:0]};
							default: begin halt_q <= 1'b1; err_q <= 1'b1; end
						endcase
					end
					OC_EAE: begin halt_q <= 1'b1; err_q <= 1'b1; end
					default: ;
				endcase
			end
			if (state_q == ST_DONE && state_d == ST_IDLE) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
		end
	end

	logic [3:0] opr_cyc;
	always_comb begin
		case (w_q)
			W_NOP, W_CMA, W_CML, W_OAS, W_RAL: opr_cyc = 4'd3;
			W_HLT: opr_cyc = 4'd4;
			W_SZA, W_SNA, W_SPA, W_SMA, W_SZL, W_SNL, W_SKP: opr_cyc = 4'd1;
			W_LAS, W_RCL, W_RTL, W_RAR, W_RCR, W_RTR,
			W_CLL, W_STL, W_CLA, W_CLC, W_GLK: opr_cyc = 4'd2;
			default: opr_cyc = 4'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= in_data.key_char;
			cyc_q <= '0;
			tv_q <= 1'b0;
			tc_q <= '0;
			rd_q <= '0;
			depth_q <= '0;
		end
		if (state_q == ST_RDWAIT) rd_q <= rdata;
		if (state_q == ST_FETCH) w_q <= rdata;
		if (state_q == ST_DECODE) ea_q <= w_q[12:0];
		if (state_q == ST_INDWAIT) ea_q <= rdata[12:0];
		if (state_q == ST_EXEC) begin
			unique case (code)
				OC_XCT: if (depth_q < XW'(MAX_XCT_CHAIN)) begin
					w_q <= rdata;
					depth_q <= depth_q + 1'b1;
					cyc_q <= cyc_q + 5'd1;
				end
				OC_ISZ: begin w_q <= inc; cyc_q <= cyc_q + 5'd2; end
				OC_JMP: cyc_q <= cyc_q + 5'd1;
				OC_IOT: if (w_q == W_TLS) begin tv_q <= 1'b1; tc_q <= ac_q[7:0]; end
				OC_OPR: cyc_q <= cyc_q + {1'b0, opr_cyc};
				OC_EAE: ;
				default: cyc_q <= cyc_q + 5'd2;
			endcase
		end
		if (state_q == ST_DONE && state_d == ST_IDLE) begin
			out_data.pc_out <= pc_q;
			out_data.acc_out <= ac_q;
			out_data.link_out <= link_q;
			out_data.halted <= halt_q;
			out_data.bad_instruction <= err_q;
			out_data.tty_valid <= tv_q;
			out_data.tty_char <= tc_q;
			out_data.read_data <= rd_q;
			out_data.step_cycles <= cyc_q > 5'd15 ? 4'd15 : cyc_q[3:0];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> in_stall)
		else $error("command taken during memory sweep");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> halt_q)
		else $error("error flag without halt");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |-> depth_q <= XW'(MAX_XCT_CHAIN))
		else $error("XCT chain depth overrun");
endmodule

// ===== hdl/amc_ram.sv =====
module amc_ram #(
	parameter int Width = 18,
	parameter int Depth = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
